FILE: src/fwrs_pkg.sv
// Package for the fractional-window running sum.
// Holds default sizes, register codes and the stage control word.
// No dependencies.
package fwrs_pkg;

  // Default sizes for the top-level parameters.
  localparam int MAX_WINDOW_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 24;

  // Configuration register widths.
  localparam int WHOLE_BITS    = 9;
  localparam int FRAC_BITS     = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WINDOW_WHOLE = 1'b0,
    REG_WINDOW_FRAC  = 1'b1
  } fwrs_reg_t;

  // Control word handed from the address stage to the accumulate stage.
  typedef struct packed {
    logic valid;     // a word occupies the stage
    logic emit;      // the word yields a result
    logic last;      // the word closes its column
    logic self_old;  // the leaving sample is the word itself (window of one)
  } fwrs_ctl_t;

endpackage

FILE: src/fwrs_hist.sv
// Delay-line memory: one write port, one registered read port.
// Uses no package items.
module fwrs_hist #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; a read of the slot being written returns the old contents.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/fwrs_ctrl.sv
// Configuration registers, fill count and delay-line addressing.
// Depends on fwrs_pkg.
module fwrs_ctrl #(
  parameter int MAX_WINDOW = fwrs_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fwrs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [fwrs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                accept,
  input  logic                                column_end,
  output logic [fwrs_pkg::FRAC_BITS-1:0]      window_frac,
  output fwrs_pkg::fwrs_ctl_t                 ctl,
  output logic [$clog2(MAX_WINDOW)-1:0]       wr_addr,
  output logic [$clog2(MAX_WINDOW)-1:0]       rd_addr
);

  localparam int ADDR_BITS = $clog2(MAX_WINDOW);
  localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int MOD_BITS  = CNT_BITS + 1;

  logic [fwrs_pkg::WHOLE_BITS-1:0] window_whole;
  logic [CNT_BITS-1:0]             fill_count;
  logic [ADDR_BITS-1:0]            write_slot;

  logic [CNT_BITS-1:0]  eff_whole;
  logic [CNT_BITS-1:0]  back;
  logic [CNT_BITS-1:0]  fill_inc;
  logic                 emit;
  logic [MOD_BITS-1:0]  old_raw;
  logic [MOD_BITS-1:0]  old_wrap;
  logic [ADDR_BITS-1:0] write_slot_next;

  // Whole window length, with zero read as one and clamped to the memory depth.
  always_comb begin
    if (window_whole == '0) begin
      eff_whole = CNT_BITS'(1);
    end else if (32'(window_whole) > 32'(MAX_WINDOW)) begin
      eff_whole = CNT_BITS'(MAX_WINDOW);
    end else begin
      eff_whole = CNT_BITS'(window_whole);
    end
  end

  assign back     = eff_whole - CNT_BITS'(1);
  assign fill_inc = fill_count + CNT_BITS'(1);
  assign emit     = (fill_inc >= eff_whole);

  // Slot of the sample that leaves the window, modulo the memory depth.
  assign old_raw  = MOD_BITS'(write_slot) + MOD_BITS'(MAX_WINDOW) - MOD_BITS'(back);
  assign old_wrap = (old_raw >= MOD_BITS'(MAX_WINDOW)) ?
                    (old_raw - MOD_BITS'(MAX_WINDOW)) : old_raw;

  assign write_slot_next = (32'(write_slot) == MAX_WINDOW - 1) ?
                           '0 : (write_slot + ADDR_BITS'(1));

  assign wr_addr = write_slot;
  assign rd_addr = old_wrap[ADDR_BITS-1:0];

  // Control word for the accepted sample.
  assign ctl.valid    = accept;
  assign ctl.emit     = emit;
  assign ctl.last     = column_end;
  assign ctl.self_old = (back == '0);

  // Registers, count and write pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_whole <= fwrs_pkg::WHOLE_BITS'(1);
      window_frac  <= '0;
      fill_count   <= '0;
      write_slot   <= '0;
    end else if (cfg_we) begin
      unique case (fwrs_pkg::fwrs_reg_t'(cfg_index))
        fwrs_pkg::REG_WINDOW_WHOLE: window_whole <= cfg_data[fwrs_pkg::WHOLE_BITS-1:0];
        fwrs_pkg::REG_WINDOW_FRAC:  window_frac  <= cfg_data[fwrs_pkg::FRAC_BITS-1:0];
        default: ;
      endcase
      fill_count <= '0;
    end else if (accept) begin
      if (column_end) begin
        fill_count <= '0;
      end else if (emit) begin
        fill_count <= back;
      end else begin
        fill_count <= fill_inc;
      end
      write_slot <= write_slot_next;
    end
  end

endmodule

FILE: src/fwrs_accum.sv
// Accumulate stage: fractional product, running total and output register.
// Depends on fwrs_pkg.
module fwrs_accum #(
  parameter int SAMPLE_BITS = fwrs_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_BITS    = 33,
  parameter int DATA_BITS   = 40
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clear,
  input  fwrs_pkg::fwrs_ctl_t               in_ctl,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  logic [fwrs_pkg::FRAC_BITS-1:0]    window_frac,
  input  logic [SAMPLE_BITS-1:0]            old_sample,
  output logic                              en,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [DATA_BITS-1:0]              m_tdata,
  output logic                              m_tlast
);

  localparam int FB = fwrs_pkg::FRAC_BITS;

  logic signed [SAMPLE_BITS+FB:0] prod;
  logic signed [SAMPLE_BITS:0]    frac_q;

  fwrs_pkg::fwrs_ctl_t         s1;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic signed [SAMPLE_BITS:0]   s1_frac;

  logic signed [SUM_BITS-1:0] total;
  logic signed [SUM_BITS-1:0] total_next;
  logic signed [SUM_BITS-1:0] sum;
  logic signed [SUM_BITS-1:0] res;
  logic signed [SUM_BITS-1:0] old_ext;
  logic [SAMPLE_BITS-1:0]     old_val;
  logic signed [SUM_BITS-1:0] m_sum;

  // Fractional weight of the incoming sample, floored by the arithmetic shift.
  assign prod   = sample * $signed({1'b0, window_frac});
  assign frac_q = prod[SAMPLE_BITS+FB:FB];

  // The stage moves unless it holds a result that the full output cannot take.
  assign en = !m_tvalid || m_tready || !(s1.valid && s1.emit);

  // Window of one: the leaving sample is the one just stored, so forward it.
  assign old_val = s1.self_old ? s1_sample : old_sample;
  assign old_ext = {{(SUM_BITS-SAMPLE_BITS){old_val[SAMPLE_BITS-1]}}, old_val};

  assign sum = total + {{(SUM_BITS-SAMPLE_BITS){s1_sample[SAMPLE_BITS-1]}}, s1_sample};
  assign res = sum + {{(SUM_BITS-SAMPLE_BITS-1){s1_frac[SAMPLE_BITS]}}, s1_frac};

  // Total after this word: clear at column end, drop the oldest on a result.
  always_comb begin
    if (s1.last) begin
      total_next = '0;
    end else if (s1.emit) begin
      total_next = sum - old_ext;
    end else begin
      total_next = sum;
    end
  end

  // Control and total.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1       <= '0;
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (!clear && en && s1.valid && s1.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (clear) begin
        total <= '0;
      end else if (en) begin
        s1 <= in_ctl;
        if (s1.valid) begin
          total <= total_next;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_sample <= sample;
      s1_frac   <= frac_q;
      if (s1.valid && s1.emit) begin
        m_sum   <= res;
        m_tlast <= s1.last;
      end
    end
  end

  assign m_tdata = DATA_BITS'($unsigned(m_sum));

endmodule

FILE: src/fractional_window_running_sum.sv
// Top level of the fractional-window running sum.
// Depends on fwrs_pkg, fwrs_ctrl, fwrs_hist and fwrs_accum.
//
//  channel  direction  handshake           payload
//  s_*      in         s_tvalid/s_tready   s_tdata: sample; s_tlast: column_end
//  m_*      out        m_tvalid/m_tready   m_tdata: window_sum; m_tlast: last_of_column
//  cfg_*    in         cfg_we              cfg_index, cfg_data
//
// One word is taken per cycle while s_tready is high. The accepting edge starts the
// delay-line read and loads the control word; the output register is filled from
// them when the accumulate stage moves on, and the result is valid from that edge.
// Reset clears registers, count and write pointer; the delay line is not cleared.
// s_tready drops only when the accumulate stage holds a result and the output
// register is full and not being taken.
module fractional_window_running_sum #(
  parameter int MAX_WINDOW  = fwrs_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = fwrs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // sample [SAMPLE_BITS-1:0], zero padding above
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // window_sum [SUM_BITS-1:0], zero padding above
  output logic [((SAMPLE_BITS+$clog2(MAX_WINDOW)+1+7)/8)*8-1:0] m_tdata,
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [fwrs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fwrs_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int ADDR_BITS = $clog2(MAX_WINDOW);
  localparam int SUM_BITS  = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int OUT_BITS  = ((SUM_BITS + 7) / 8) * 8;

  logic                              en;
  logic                              accept;
  logic signed [SAMPLE_BITS-1:0]     sample;
  logic [fwrs_pkg::FRAC_BITS-1:0]    window_frac;
  fwrs_pkg::fwrs_ctl_t               ctl;
  logic [ADDR_BITS-1:0]              wr_addr;
  logic [ADDR_BITS-1:0]              rd_addr;
  logic [SAMPLE_BITS-1:0]            old_sample;

  assign s_tready = en;
  assign accept   = s_tvalid && en;
  assign sample   = s_tdata[SAMPLE_BITS-1:0];

  // Registers and addressing.
  fwrs_ctrl #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .column_end (s_tlast),
    .window_frac(window_frac),
    .ctl        (ctl),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr)
  );

  // Delay line.
  fwrs_hist #(
    .DEPTH(MAX_WINDOW),
    .WIDTH(SAMPLE_BITS)
  ) u_hist (
    .clk  (clk),
    .we   (accept),
    .waddr(wr_addr),
    .wdata(sample),
    .re   (en),
    .raddr(rd_addr),
    .rdata(old_sample)
  );

  // Running total and output register.
  fwrs_accum #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_BITS   (SUM_BITS),
    .DATA_BITS  (OUT_BITS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .clear      (cfg_we),
    .in_ctl     (ctl),
    .sample     (sample),
    .window_frac(window_frac),
    .old_sample (old_sample),
    .en         (en),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
